@@ rtl/vsa_pkg.sv @@
package vsa_pkg;

  localparam int SlotsDefault = 64;
  localparam int TIME_W       = 18;
  localparam int TICK_W       = 16;
  localparam int SLOT_W       = 6;

  localparam logic [TICK_W-1:0] TICK_RESET = 16'd240;

  // command codes
  localparam logic CMD_PLAY = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic              command;
    logic [TIME_W-1:0] length_samples;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              reused;
    logic              pool_full;
  } out_item_t;

  // controls from the sequencer to the slot store
  typedef struct packed {
    logic rd_en;
    logic time_we;
    logic next_we;
    logic prev_we;
  } store_ctl_t;

endpackage

@@ rtl/vsa_store.sv @@
module vsa_store import vsa_pkg::*; #(
  parameter int SLOTS = SlotsDefault,
  localparam int LW = $clog2(SLOTS + 1),
  localparam int IW = $clog2(SLOTS)
) (
  input  logic              clk,
  input  store_ctl_t        ctl,
  input  logic [IW-1:0]     rd_addr,
  input  logic [IW-1:0]     time_addr,
  input  logic [TIME_W-1:0] time_wdata,
  input  logic [IW-1:0]     link_addr,
  input  logic [LW-1:0]     next_wdata,
  input  logic [LW-1:0]     prev_wdata,
  output logic [TIME_W-1:0] rd_time,
  output logic [LW-1:0]     rd_next,
  output logic [LW-1:0]     rd_prev
);

  // remaining time per slot, and {next, prev} links per slot
  logic [TIME_W-1:0] time_mem [SLOTS];
  logic [2*LW-1:0]   link_mem [SLOTS];
  logic [2*LW-1:0]   rd_link;

  always_ff @(posedge clk) begin
    if (ctl.time_we) begin
      time_mem[time_addr] <= time_wdata;
    end
    if (ctl.next_we) begin
      link_mem[link_addr][2*LW-1:LW] <= next_wdata;
    end
    if (ctl.prev_we) begin
      link_mem[link_addr][LW-1:0] <= prev_wdata;
    end
    if (ctl.rd_en) begin
      rd_time <= time_mem[rd_addr];
      rd_link <= link_mem[rd_addr];
    end
  end

  assign rd_next = rd_link[2*LW-1:LW];
  assign rd_prev = rd_link[LW-1:0];

endmodule

@@ rtl/vsa_seq.sv @@
module vsa_seq import vsa_pkg::*; #(
  parameter int SLOTS = SlotsDefault,
  localparam int LW = $clog2(SLOTS + 1),
  localparam int IW = $clog2(SLOTS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  in_item_t          in_data,
  output logic              busy,
  input  logic [TICK_W-1:0] tick_samples,
  output logic              res_valid,
  output out_item_t         res_data,
  input  logic              res_ready,
  output store_ctl_t        ctl,
  output logic [IW-1:0]     rd_addr,
  output logic [IW-1:0]     time_addr,
  output logic [TIME_W-1:0] time_wdata,
  output logic [IW-1:0]     link_addr,
  output logic [LW-1:0]     next_wdata,
  output logic [LW-1:0]     prev_wdata,
  input  logic [TIME_W-1:0] rd_time,
  input  logic [LW-1:0]     rd_next,
  input  logic [LW-1:0]     rd_prev
);

  localparam logic [LW-1:0] NIL = LW'(SLOTS);

  typedef enum logic [2:0] {
    IDLE, WALK, FRESH, UNL_N, UNL_P, LNK_S, LNK_H, FIN
  } state_t;

  state_t            state;
  logic              cmd;
  logic [TIME_W-1:0] len;
  logic [LW-1:0]     head;
  logic [LW-1:0]     used;
  logic [LW-1:0]     cur;
  logic [LW-1:0]     nxt;
  logic [LW-1:0]     prv;
  logic              reuse;

  logic [TIME_W-1:0] tick_ext;
  logic [TIME_W-1:0] time_sat;

  assign tick_ext = TIME_W'(tick_samples);
  assign time_sat = (rd_time > tick_ext) ? rd_time - tick_ext : '0;

  assign busy      = (state != IDLE);
  assign res_valid = (state == FIN);
  assign time_addr = cur[IW-1:0];

  always_comb begin
    ctl        = '0;
    rd_addr    = head[IW-1:0];
    link_addr  = cur[IW-1:0];
    time_wdata = len;
    next_wdata = head;
    prev_wdata = NIL;
    case (state)
      IDLE: begin
        ctl.rd_en = in_valid && (head != NIL);
      end
      WALK: begin
        rd_addr = rd_next[IW-1:0];
        if (cmd == CMD_TICK) begin
          // saturate the visited slot, fetch the next one
          ctl.time_we = 1'b1;
          time_wdata  = time_sat;
          ctl.rd_en   = (rd_next != NIL);
        end else begin
          ctl.rd_en = (rd_time != '0) && (rd_next != NIL);
        end
      end
      UNL_N: begin
        ctl.prev_we = (nxt != NIL);
        link_addr   = nxt[IW-1:0];
        prev_wdata  = prv;
      end
      UNL_P: begin
        ctl.next_we = (prv != NIL);
        link_addr   = prv[IW-1:0];
        next_wdata  = nxt;
      end
      LNK_S: begin
        ctl.time_we = 1'b1;
        ctl.next_we = 1'b1;
        ctl.prev_we = 1'b1;
      end
      LNK_H: begin
        ctl.prev_we = (head != NIL);
        link_addr   = head[IW-1:0];
        prev_wdata  = cur;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      head  <= NIL;
      used  <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (in_valid) begin
            cmd <= in_data.command;
            len <= in_data.length_samples;
            cur <= head;
            if (head != NIL) begin
              state <= WALK;
            end else if (in_data.command == CMD_PLAY) begin
              state <= FRESH;
            end
          end
        end
        WALK: begin
          if (cmd == CMD_TICK) begin
            if (rd_next == NIL) begin
              state <= IDLE;
            end
            cur <= rd_next;
          end else if (rd_time == '0) begin
            nxt   <= rd_next;
            prv   <= rd_prev;
            state <= UNL_N;
          end else if (rd_next == NIL) begin
            state <= FRESH;
          end else begin
            cur <= rd_next;
          end
        end
        FRESH: begin
          if (used != NIL) begin
            cur   <= used;
            used  <= used + 1'b1;
            reuse <= 1'b0;
            state <= LNK_S;
          end else begin
            res_data <= '{slot: '0, reused: 1'b0, pool_full: 1'b1};
            state    <= FIN;
          end
        end
        UNL_N: begin
          state <= UNL_P;
        end
        UNL_P: begin
          if (head == cur) begin
            head <= nxt;
          end
          reuse <= 1'b1;
          state <= LNK_S;
        end
        LNK_S: begin
          state <= LNK_H;
        end
        LNK_H: begin
          head     <= cur;
          res_data <= '{slot: SLOT_W'(cur), reused: reuse, pool_full: 1'b0};
          state    <= FIN;
        end
        FIN: begin
          if (res_ready) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/voice_slot_allocator_unit.sv @@
// Voice slot allocator. A play transfer (command 0) walks the list of started
// slots from the most recently started one and takes the first slot whose
// remaining time is zero (reused = 1); failing that it takes the next
// never-used slot (reused = 0); with every slot in use and none expired it
// returns pool_full = 1, slot = 0 and changes nothing. The chosen slot is
// loaded with length_samples and moved to the head of the list. A tick
// transfer (command 1) subtracts tick_samples from every listed slot,
// stopping at zero, and returns no result. Timing: the walk visits one slot
// per cycle through the read port of the slot store. in_stall is high
// while an item is in progress; a finished result sits in the output
// register, and the next item is taken while it waits there.
// tick_samples may be written only while the block is idle; it resets to
// 240. The slot store needs no clearing after reset.
module voice_slot_allocator_unit import vsa_pkg::*; #(
  parameter int SLOTS = SlotsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [TICK_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data
);

  localparam int LW = $clog2(SLOTS + 1);
  localparam int IW = $clog2(SLOTS);

  logic [TICK_W-1:0] tick_samples;
  logic              busy;
  logic              res_valid;
  out_item_t         res_data;
  logic              res_ready;
  store_ctl_t        ctl;
  logic [IW-1:0]     rd_addr;
  logic [IW-1:0]     time_addr;
  logic [TIME_W-1:0] time_wdata;
  logic [IW-1:0]     link_addr;
  logic [LW-1:0]     next_wdata;
  logic [LW-1:0]     prev_wdata;
  logic [TIME_W-1:0] rd_time;
  logic [LW-1:0]     rd_next;
  logic [LW-1:0]     rd_prev;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_samples <= TICK_RESET;
    end else if (cfg_wr_en) begin
      tick_samples <= cfg_wr_data;
    end
  end

  assign in_stall = busy;

  // output register: load when empty or being drained
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_data <= res_data;
    end
  end

  vsa_seq #(.SLOTS(SLOTS)) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_data      (in_data),
    .busy         (busy),
    .tick_samples (tick_samples),
    .res_valid    (res_valid),
    .res_data     (res_data),
    .res_ready    (res_ready),
    .ctl          (ctl),
    .rd_addr      (rd_addr),
    .time_addr    (time_addr),
    .time_wdata   (time_wdata),
    .link_addr    (link_addr),
    .next_wdata   (next_wdata),
    .prev_wdata   (prev_wdata),
    .rd_time      (rd_time),
    .rd_next      (rd_next),
    .rd_prev      (rd_prev)
  );

  vsa_store #(.SLOTS(SLOTS)) u_store (
    .clk        (clk),
    .ctl        (ctl),
    .rd_addr    (rd_addr),
    .time_addr  (time_addr),
    .time_wdata (time_wdata),
    .link_addr  (link_addr),
    .next_wdata (next_wdata),
    .prev_wdata (prev_wdata),
    .rd_time    (rd_time),
    .rd_next    (rd_next),
    .rd_prev    (rd_prev)
  );

endmodule

@@ rtl/vsa_checker.sv @@
module vsa_checker import vsa_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input in_item_t          in_data,
  input logic              out_valid,
  input logic              out_stall,
  input out_item_t         out_data
);

  // a stalled input transfer holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a full pool reports no slot
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.pool_full |-> !out_data.reused && (out_data.slot == '0))
    else $error("pool_full result carries a slot");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // a new result comes only from an item in progress
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in progress");

endmodule

bind voice_slot_allocator_unit vsa_checker u_vsa_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_data     (in_data),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_data    (out_data)
);
